@@ sv/gibb_pkg.sv @@
// Package for the glyph ink bounding box block: transaction types, sizing
// constants and the divide-by-three constants. No dependencies.
`timescale 1ns / 1ps

package gibb_pkg;

    // Largest glyph cell edge in pixels; counters saturate one below it.
    localparam int MAX_DIM = 256;
    localparam int COORD_W = $clog2(MAX_DIM);
    localparam int LEN_W   = $clog2(MAX_DIM + 1);
    localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(MAX_DIM - 1);

    // Channel sum is at most 765; (sum * 683) >> 11 equals sum / 3 there.
    localparam int SUM_W      = 10;
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int PROD_W     = 20;

    typedef struct packed {
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
        logic       row_end;
        logic       glyph_end;
    } pixel_t;

    typedef struct packed {
        logic [7:0] alpha_level;
        logic       box_ready;
        logic [7:0] box_left;
        logic [7:0] box_top;
        logic [8:0] box_width;
        logic [8:0] box_height;
    } result_t;

endpackage

@@ sv/gibb_alpha.sv @@
// Alpha unit: average of the three color channels, rounded down.
// Depends on gibb_pkg for the divide-by-three constants.
`timescale 1ns / 1ps

module gibb_alpha (
    input  gibb_pkg::pixel_t   pixel,
    output logic [7:0]         alpha
);
    import gibb_pkg::*;

    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] prod;

    // Division by three is a multiply by a scaled reciprocal and a shift.
    always_comb
    begin
        sum   = SUM_W'(pixel.red_level) + SUM_W'(pixel.green_level)
              + SUM_W'(pixel.blue_level);
        prod  = PROD_W'(sum) * PROD_W'(DIV3_MUL);
        alpha = prod[DIV3_SHIFT +: 8];
    end

endmodule

@@ sv/gibb_tracker.sv @@
// Ink tracker: position counters, ink extremes and the padded box at glyph end.
// Depends on gibb_pkg for the transaction types and sizing constants.
`timescale 1ns / 1ps

module gibb_tracker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  gibb_pkg::pixel_t  pixel,
    input  logic [7:0]        alpha,
    output gibb_pkg::result_t result
);
    import gibb_pkg::*;

    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               ink_reg, ink_next;
    logic [COORD_W-1:0] lcol_reg, lcol_next;
    logic [COORD_W-1:0] lrow_reg, lrow_next;
    logic [COORD_W-1:0] gcol_reg, gcol_next;
    logic [COORD_W-1:0] grow_reg, grow_next;
    logic [COORD_W-1:0] ext_w, ext_h;
    logic               line_end;

    always_comb
    begin
        ink_next  = ink_reg;
        lcol_next = lcol_reg;
        lrow_next = lrow_reg;
        gcol_next = gcol_reg;
        grow_next = grow_reg;
        len_next  = len_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        result    = '0;
        result.alpha_level = alpha;

        // Extremes take the current pixel into account before the box is formed.
        if (alpha != 8'd0)
        begin
            if (!ink_reg)
            begin
                ink_next  = 1'b1;
                lcol_next = col_reg;
                gcol_next = col_reg;
                lrow_next = row_reg;
                grow_next = row_reg;
            end
            else
            begin
                if (col_reg < lcol_reg) lcol_next = col_reg;
                if (col_reg > gcol_reg) gcol_next = col_reg;
                if (row_reg < lrow_reg) lrow_next = row_reg;
                if (row_reg > grow_reg) grow_next = row_reg;
            end
        end

        // Glyph end also closes the current row.
        line_end = pixel.row_end | pixel.glyph_end;
        if (line_end)
        begin
            len_next = LEN_W'(col_reg) + LEN_W'(1);
            col_next = '0;
            if (row_reg < COORD_MAX) row_next = row_reg + COORD_W'(1);
        end
        else if (col_reg < COORD_MAX)
        begin
            col_next = col_reg + COORD_W'(1);
        end

        ext_w = gcol_next - lcol_next;
        ext_h = grow_next - lrow_next;

        if (pixel.glyph_end)
        begin
            result.box_ready = 1'b1;
            if (!ink_next || ext_w == '0 || ext_h == '0)
            begin
                result.box_width = 9'(len_next);
            end
            else
            begin
                result.box_left   = 8'((lcol_next != '0) ? lcol_next - COORD_W'(1) : '0);
                result.box_top    = 8'((lrow_next != '0) ? lrow_next - COORD_W'(1) : '0);
                result.box_width  = 9'(ext_w) + 9'd2;
                result.box_height = 9'(ext_h) + 9'd2;
            end
            ink_next  = 1'b0;
            lcol_next = '0;
            lrow_next = '0;
            gcol_next = '0;
            grow_next = '0;
            len_next  = '0;
            col_next  = '0;
            row_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            len_reg  <= '0;
            ink_reg  <= 1'b0;
            lcol_reg <= '0;
            lrow_reg <= '0;
            gcol_reg <= '0;
            grow_reg <= '0;
        end
        else if (advance)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            len_reg  <= len_next;
            ink_reg  <= ink_next;
            lcol_reg <= lcol_next;
            lrow_reg <= lrow_next;
            gcol_reg <= gcol_next;
            grow_reg <= grow_next;
        end
    end

`ifndef ASSERT_OFF
    a_extremes_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        ink_reg |-> (lcol_reg <= gcol_reg && lrow_reg <= grow_reg))
        else $error("ink extremes out of order");

    a_clear_after_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        advance && pixel.glyph_end |=> (!ink_reg && col_reg == '0 && row_reg == '0))
        else $error("tracker not cleared after glyph end");

    a_empty_without_ink: assert property (@(posedge clk) disable iff (!rst_n)
        !ink_reg |-> (lcol_reg == '0 && gcol_reg == '0 && lrow_reg == '0
                      && grow_reg == '0))
        else $error("extremes set without ink");
`endif

endmodule

@@ sv/glyph_ink_bounding_box_top.sv @@
// Top level of the glyph ink bounding box block: input and result registers
// and the handshake. Depends on gibb_pkg, gibb_alpha and gibb_tracker.
`timescale 1ns / 1ps

// Usage:
// Pixels of one glyph cell arrive in raster order on the pixel channel
// (pixel_valid, pixel_stall, pixel_data). The last pixel of each row carries
// row_end, and the last pixel of the cell carries glyph_end. Every pixel
// transaction yields exactly one result transaction on the result channel
// (result_valid, result_stall, result_data) holding its alpha level. On the
// glyph_end pixel the result also carries box_ready and the padded ink box
// (or, with no ink or ink one line thick, only the last row's length as the
// width); on other pixels the box fields are zero.
// Path: an accepted pixel waits in the input register while it is processed,
// and its result moves into the result register, raising result_valid.
// Throughput: one pixel per clock while result_stall stays low. The input and
// result registers each hold one transaction, and all per-pixel work (alpha,
// extremes, box) is one short combinational pass between them.
// Stalls: while result_stall holds a waiting result, one more pixel is still
// accepted into the input register; pixel_stall rises only when both
// registers are full. Reset (rst_n low) empties both registers and clears
// the counters and ink extremes, so the next pixel starts a new glyph cell.
module glyph_ink_bounding_box_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pixel_valid,
    output logic               pixel_stall,
    input  gibb_pkg::pixel_t   pixel_data,
    output logic               result_valid,
    input  logic               result_stall,
    output gibb_pkg::result_t  result_data
);
    import gibb_pkg::*;

    pixel_t     pixel_reg;
    logic       pix_valid_reg, pix_valid_next;
    result_t    result_reg;
    result_t    result_next;
    logic       res_valid_reg, res_valid_next;
    logic [7:0] alpha;
    logic       res_load;
    logic       pix_load;
    logic       advance;

    // The result register can take a new transaction when it is empty or
    // being drained; the input register can when it is empty or its pixel moves on.
    always_comb
    begin
        res_load       = !res_valid_reg || !result_stall;
        advance        = pix_valid_reg && res_load;
        pix_load       = !pix_valid_reg || res_load;
        pixel_stall    = !pix_load;
        pix_valid_next = pix_load ? pixel_valid : pix_valid_reg;
        res_valid_next = res_load ? pix_valid_reg : res_valid_reg;
    end

    gibb_alpha u_alpha (
        .pixel (pixel_reg),
        .alpha (alpha)
    );

    // The tracker updates its state only when the pixel moves into the
    // result register, so each pixel is counted exactly once.
    gibb_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .pixel   (pixel_reg),
        .alpha   (alpha),
        .result  (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pix_valid_reg <= pix_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers load only on a transfer and carry no reset.
    always_ff @(posedge clk)
    begin
        if (pixel_valid && pix_load)
        begin
            pixel_reg <= pixel_data;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result_data  = result_reg;

`ifndef ASSERT_OFF
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (pix_valid_reg && res_valid_reg && result_stall))
        else $error("pixel channel stalled with room available");

    a_box_zero_when_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_data.box_ready |->
            (result_data.box_left == 8'd0 && result_data.box_top == 8'd0
             && result_data.box_width == 9'd0 && result_data.box_height == 9'd0))
        else $error("box fields set on a pixel without glyph end");

    a_box_padded: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.box_height != 9'd0 |->
            (result_data.box_height >= 9'd3 && result_data.box_width >= 9'd3))
        else $error("nonempty box smaller than its padding");

    a_result_follows_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid)
        else $error("processed pixel produced no result");
`endif

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for glyph_ink_bounding_box_top: a directed stimulus
// table followed by random glyph cells, checked against a behavioral predictor.
// Depends on gibb_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
    import gibb_pkg::*;

    // The watchdog ends the run when the cycle counter reaches this.
    localparam int LIMIT_CYCLES = 200000;
    // Least count of random pixels after the directed table; the last cell is sent whole.
    localparam int RANDOM_PIXELS = 1200;
    // Random pixels spent in each idling phase before moving to the next one.
    localparam int PHASE_PIXELS = 250;
    // How long the receiver holds off to back the block up into its input.
    localparam int HOLD_OFF_CYCLES = 64;
    // Mismatch lines printed before the report task goes quiet (it keeps counting).
    localparam int SHOW_LIMIT = 40;
    // Quiet time allowed after the last result before the verdict.
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef enum logic [1:0] {
        SHAPE_PLAIN,
        SHAPE_WIDE,
        SHAPE_TALL,
        SHAPE_NOISE
    } glyph_shape_t;

    // One row of the directed table. Where pinned is set, the expected result
    // is the hand-typed one; otherwise the predictor supplies it.
    typedef struct {
        pixel_t  px;
        bit      pinned;
        result_t want;
    } directed_row_t;

    logic    clk;
    logic    rst_n;
    logic    pixel_valid;
    logic    pixel_stall;
    pixel_t  pixel_data;
    logic    result_valid;
    logic    result_stall;
    result_t result_data;

    glyph_ink_bounding_box_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel_data   (pixel_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    // Shared between the stimulus process and the receiver process. Both are
    // written by the stimulus process with nonblocking assignments at the
    // falling edge, so the receiver sees them one step later at most.
    idle_mode_t idle_mode;
    bit         hold_request;

    // Results still owed by the block, oldest first.
    result_t       pending_results[$];
    directed_row_t directed_rows[$];
    int            pixels_sent;
    int            mismatches;
    int            cycle_count;
    // Once set, the idling phase follows the count of random pixels sent.
    bit            phases_on;
    int            random_base;

    // Predictor state, kept at the block's own widths. The ink extremes mean
    // something only while has_ink is set.
    logic [COORD_W-1:0] at_column;
    logic [COORD_W-1:0] at_row;
    logic [LEN_W-1:0]   last_row_length;
    bit                 has_ink;
    logic [COORD_W-1:0] ink_left;
    logic [COORD_W-1:0] ink_right;
    logic [COORD_W-1:0] ink_top;
    logic [COORD_W-1:0] ink_bottom;

    // Clock: 8 ns period.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Start of a new glyph cell: used after reset and after every glyph end.
    function automatic void clear_glyph_state();
        at_column       = '0;
        at_row          = '0;
        last_row_length = '0;
        has_ink         = 1'b0;
        ink_left        = '0;
        ink_right       = '0;
        ink_top         = '0;
        ink_bottom      = '0;
    endfunction

    // Appends one row to the directed table.
    function automatic void add_directed(pixel_t px, bit pinned, result_t want);
        directed_row_t row;
        row.px     = px;
        row.pinned = pinned;
        row.want   = want;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Works out the result transaction that one accepted pixel causes and
    // advances the predictor state the way the block advances its own.
    function automatic result_t predict_ink_box(pixel_t px);
        int      channel_sum;
        int      span_w;
        int      span_h;
        result_t res;
        res = '0;
        channel_sum = int'(px.red_level) + int'(px.green_level) + int'(px.blue_level);
        res.alpha_level = 8'(channel_sum / 3);

        // Any nonzero alpha counts as ink, at the position the pixel sits in.
        if (res.alpha_level != 8'd0)
        begin
            if (!has_ink)
            begin
                has_ink    = 1'b1;
                ink_left   = at_column;
                ink_right  = at_column;
                ink_top    = at_row;
                ink_bottom = at_row;
            end
            else
            begin
                if (at_column < ink_left)
                    ink_left = at_column;
                if (at_column > ink_right)
                    ink_right = at_column;
                if (at_row < ink_top)
                    ink_top = at_row;
                if (at_row > ink_bottom)
                    ink_bottom = at_row;
            end
        end

        // A glyph end also closes the current row. Both counters hold at the
        // top of their range, and the row length saturates at MAX_DIM.
        if (px.row_end || px.glyph_end)
        begin
            if (int'(at_column) + 1 > MAX_DIM)
                last_row_length = LEN_W'(MAX_DIM);
            else
                last_row_length = LEN_W'(int'(at_column) + 1);
            at_column = '0;
            if (at_row < COORD_MAX)
                at_row = at_row + 1'b1;
        end
        else if (at_column < COORD_MAX)
        begin
            at_column = at_column + 1'b1;
        end

        if (px.glyph_end)
        begin
            res.box_ready = 1'b1;
            span_w = int'(ink_right) - int'(ink_left);
            span_h = int'(ink_bottom) - int'(ink_top);
            // An empty box, or one that is a single line thick, reports only
            // the length of the last row.
            if (!has_ink || span_w == 0 || span_h == 0)
            begin
                res.box_width = 9'(last_row_length);
            end
            else
            begin
                res.box_left   = (ink_left > 0) ? ink_left - 1'b1 : 8'd0;
                res.box_top    = (ink_top > 0) ? ink_top - 1'b1 : 8'd0;
                res.box_width  = 9'(span_w + 2);
                res.box_height = 9'(span_h + 2);
            end
            clear_glyph_state();
        end
        return res;
    endfunction

    // Chance in percent that a side idles in this cycle under the current mode.
    function automatic int idle_percent(bit sender_side);
        case (idle_mode)
            IDLE_SENDER:   return sender_side ? 81 : 0;
            IDLE_RECEIVER: return sender_side ? 0 : 81;
            IDLE_BOTH:     return 10;
            default:       return 0;
        endcase
    endfunction

    // Inked pixels get random channels with a sum of at least three, so their
    // alpha is nonzero. Blank pixels are either all zero or carry a few stray
    // bits that still round down to alpha zero.
    function automatic pixel_t make_pixel(bit inked, bit ends_row, bit ends_glyph);
        pixel_t px;
        px = '0;
        if (inked)
        begin
            px.red_level   = 8'($urandom_range(0, 255));
            px.green_level = 8'($urandom_range(0, 255));
            px.blue_level  = 8'($urandom_range(0, 255));
            if (int'(px.red_level) + int'(px.green_level) + int'(px.blue_level) < 3)
                px.red_level = 8'($urandom_range(3, 255));
        end
        else if ($urandom_range(0, 1) == 1)
        begin
            px.red_level   = 8'($urandom_range(0, 2));
            px.green_level = 8'($urandom_range(0, 2 - int'(px.red_level)));
            px.blue_level  = 8'($urandom_range(0, 2 - int'(px.red_level)
                                                  - int'(px.green_level)));
        end
        px.row_end   = ends_row;
        px.glyph_end = ends_glyph;
        return px;
    endfunction

    // Mismatch report: one line per problem, counted whether printed or not.
    task automatic note_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
            $display("[%0t] %s: got %0d, wanted %0d", $time, what, got, want);
    endtask

    // Offers one pixel transaction. Entered and left at a falling edge, so the
    // payload only ever changes there. Valid may drop for random idle cycles
    // first; once raised it stays up, with the payload held, until accepted.
    task automatic offer_pixel(input pixel_t px, input bit pinned, input result_t want);
        result_t predicted;
        if (phases_on)
            idle_mode <= idle_mode_t'(((pixels_sent - random_base) / PHASE_PIXELS) % 4);
        while ($urandom_range(0, 99) < idle_percent(1'b1))
        begin
            pixel_valid <= 1'b0;
            @(negedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_data  <= px;
        do
            @(posedge clk);
        while (pixel_stall);
        // Accepted at this edge. The predictor always runs so its state tracks
        // the block; a pinned row overrides only what is expected back.
        predicted = predict_ink_box(px);
        pending_results.insert(pending_results.size(), pinned ? want : predicted);
        pixels_sent++;
        @(negedge clk);
    endtask

    // One random glyph cell. Plain cells are small, with a random ink density
    // and sometimes ragged rows; wide and tall cells push the column and row
    // counters past their limits with full ink, so the box reaches its largest
    // extent. Noise is a short run of pixels with random flags.
    task automatic send_glyph(input glyph_shape_t shape);
        int     rows;
        int     cols;
        int     row_cols;
        int     ink_pct;
        bit     closes_last_row;
        bit     last_in_row;
        bit     last_row;
        pixel_t px;
        if (shape == SHAPE_NOISE)
        begin
            repeat ($urandom_range(1, 20))
            begin
                px = make_pixel($urandom_range(0, 99) < 50, $urandom_range(0, 99) < 30,
                                $urandom_range(0, 99) < 10);
                offer_pixel(px, 1'b0, '0);
            end
        end
        else
        begin
            case (shape)
                SHAPE_WIDE:
                begin
                    rows    = 2;
                    cols    = $urandom_range(MAX_DIM, MAX_DIM + 6);
                    ink_pct = 100;
                end
                SHAPE_TALL:
                begin
                    rows    = $urandom_range(MAX_DIM, MAX_DIM + 6);
                    cols    = 2;
                    ink_pct = 100;
                end
                default:
                begin
                    rows = $urandom_range(1, 8);
                    cols = $urandom_range(1, 12);
                    case ($urandom_range(0, 3))
                        0:       ink_pct = 0;
                        1:       ink_pct = 8;
                        2:       ink_pct = 35;
                        default: ink_pct = 90;
                    endcase
                end
            endcase
            // Half the cells end on a pixel that carries only the glyph end.
            closes_last_row = 1'($urandom_range(0, 1));
            for (int r = 0; r < rows; r++)
            begin
                if (shape == SHAPE_PLAIN && $urandom_range(0, 3) == 0)
                    row_cols = $urandom_range(1, cols);
                else
                    row_cols = cols;
                for (int c = 0; c < row_cols; c++)
                begin
                    last_in_row = (c == row_cols - 1);
                    last_row    = (r == rows - 1);
                    px = make_pixel($urandom_range(0, 99) < ink_pct,
                                    last_in_row && (!last_row || closes_last_row),
                                    last_in_row && last_row);
                    offer_pixel(px, 1'b0, '0);
                end
            end
        end
    endtask

    // Receiver: drives result_stall at every falling edge. Once the stimulus
    // asks for it, it holds off for a long stretch that it counts itself, so
    // that the block fills both of its registers and stalls its input.
    initial
    begin
        int hold_left;
        bit hold_taken;
        hold_left    = 0;
        hold_taken   = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= ($urandom_range(0, 99) < idle_percent(1'b0));
            end
        end
    end

    // Result checker: every accepted result transaction is held against the
    // oldest expectation, field by field.
    initial
    begin
        result_t want;
        mismatches = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    note_mismatch("result with nothing pending", int'(result_data.alpha_level), 0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result_data.alpha_level !== want.alpha_level)
                        note_mismatch("alpha_level", int'(result_data.alpha_level),
                                      int'(want.alpha_level));
                    if (result_data.box_ready !== want.box_ready)
                        note_mismatch("box_ready", int'(result_data.box_ready),
                                      int'(want.box_ready));
                    if (result_data.box_left !== want.box_left)
                        note_mismatch("box_left", int'(result_data.box_left),
                                      int'(want.box_left));
                    if (result_data.box_top !== want.box_top)
                        note_mismatch("box_top", int'(result_data.box_top),
                                      int'(want.box_top));
                    if (result_data.box_width !== want.box_width)
                        note_mismatch("box_width", int'(result_data.box_width),
                                      int'(want.box_width));
                    if (result_data.box_height !== want.box_height)
                        note_mismatch("box_height", int'(result_data.box_height),
                                      int'(want.box_height));
                end
            end
        end
    end

    // Watchdog: a run that has not finished by the limit has hung.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("glyph_ink_bounding_box_top: mismatch");
        $finish;
    end

    // Stimulus: reset, the directed table, then random glyph cells through
    // the idling phases, then drain and give the verdict.
    initial
    begin
        int           glyph_count;
        glyph_shape_t shape;
        rst_n        = 1'b0;
        pixel_valid  = 1'b0;
        pixel_data   = '0;
        idle_mode    = IDLE_NONE;
        hold_request = 1'b0;
        pixels_sent  = 0;
        phases_on    = 1'b0;
        random_base  = 0;
        clear_glyph_state();

        // Glyph with a single ink pixel, closed by a pixel that ends the glyph
        // but not its row: alpha extremes first, then a degenerate box whose
        // width is the length of the row the glyph end closes (three).
        add_directed('{8'd0, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b1,
                     '{8'd0, 1'b0, 8'd0, 8'd0, 9'd0, 9'd0});
        add_directed('{8'd255, 8'd255, 8'd255, 1'b0, 1'b0}, 1'b1,
                     '{8'd255, 1'b0, 8'd0, 8'd0, 9'd0, 9'd0});
        add_directed('{8'd1, 8'd1, 8'd0, 1'b0, 1'b0}, 1'b1,
                     '{8'd0, 1'b0, 8'd0, 8'd0, 9'd0, 9'd0});
        add_directed('{8'd0, 8'd0, 8'd2, 1'b1, 1'b0}, 1'b1,
                     '{8'd0, 1'b0, 8'd0, 8'd0, 9'd0, 9'd0});
        add_directed('{8'd0, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b0, '0);
        add_directed('{8'd0, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b0, '0);
        add_directed('{8'd0, 8'd0, 8'd0, 1'b0, 1'b1}, 1'b1,
                     '{8'd0, 1'b1, 8'd0, 8'd0, 9'd3, 9'd0});
        // Two by two glyph inked on its diagonal: box at the origin, which
        // cannot move back, with both extents one plus two.
        add_directed('{8'd3, 8'd3, 8'd3, 1'b0, 1'b0}, 1'b1,
                     '{8'd3, 1'b0, 8'd0, 8'd0, 9'd0, 9'd0});
        add_directed('{8'd0, 8'd0, 8'd0, 1'b1, 1'b0}, 1'b0, '0);
        add_directed('{8'd0, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b0, '0);
        add_directed('{8'd9, 8'd0, 8'd0, 1'b1, 1'b1}, 1'b1,
                     '{8'd3, 1'b1, 8'd0, 8'd0, 9'd3, 9'd3});
        // One-pixel glyph with no ink at all.
        add_directed('{8'd0, 8'd0, 8'd0, 1'b0, 1'b1}, 1'b1,
                     '{8'd0, 1'b1, 8'd0, 8'd0, 9'd1, 9'd0});
        // Four by three glyph with ink away from the top left, so the origin
        // moves back by one on both axes.
        add_directed('{8'd0, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b0, '0);
        add_directed('{8'd0, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b0, '0);
        add_directed('{8'd0, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b0, '0);
        add_directed('{8'd0, 8'd0, 8'd0, 1'b1, 1'b0}, 1'b0, '0);
        add_directed('{8'd0, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b0, '0);
        add_directed('{8'd0, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b0, '0);
        add_directed('{8'd4, 8'd5, 8'd6, 1'b0, 1'b0}, 1'b0, '0);
        add_directed('{8'd0, 8'd0, 8'd0, 1'b1, 1'b0}, 1'b0, '0);
        add_directed('{8'd0, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b0, '0);
        add_directed('{8'd0, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b0, '0);
        add_directed('{8'd0, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b0, '0);
        add_directed('{8'd200, 8'd100, 8'd50, 1'b0, 1'b1}, 1'b0, '0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer_pixel(directed_rows[i].px, directed_rows[i].pinned, directed_rows[i].want);

        // The random part opens with no idling and a long receiver hold-off,
        // so the sender keeps offering into a full block. The idling phase
        // steps pixel by pixel, so even the long wide and tall cells pass
        // through every phase; one wide and one tall cell are placed early so
        // the counter limits are always reached.
        hold_request <= 1'b1;
        random_base = pixels_sent;
        phases_on   = 1'b1;
        glyph_count = 0;
        while (pixels_sent - random_base < RANDOM_PIXELS)
        begin
            if (glyph_count == 3)
                shape = SHAPE_WIDE;
            else if (glyph_count == 7)
                shape = SHAPE_TALL;
            else if ($urandom_range(0, 99) < 10)
                shape = SHAPE_NOISE;
            else
                shape = SHAPE_PLAIN;
            send_glyph(shape);
            glyph_count++;
        end
        pixel_valid <= 1'b0;

        // Drain, then leave room for any stray result before the verdict.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("glyph_ink_bounding_box_top: match");
        else
            $display("glyph_ink_bounding_box_top: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/gibb_pkg.sv
sv/gibb_alpha.sv
sv/gibb_tracker.sv
sv/glyph_ink_bounding_box_top.sv
tb/tb.sv
